### rtl/dssf_pkg.sv
`timescale 1ns / 1ps
package dssf_pkg;

   localparam int VALUE_W  = 16;
   localparam int DIGITS   = 4;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int BEATS    = 10;
   localparam int FRAME_LEN = 5;
   localparam int CNT_W    = 4;
   localparam logic [CNT_W-1:0] LAST_BEAT = CNT_W'(BEATS - 1);
   localparam logic [7:0] START_BIT = 8'h80;

   typedef struct packed {
      logic                line;
      logic [VALUE_W-1:0]  bin;
      logic [BCD_W-1:0]    bcd;
      logic                big;
   } cell_data_type;

   // segments a..g = bit 6..0
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'h7E;
         4'd1:    code = 8'h30;
         4'd2:    code = 8'h6D;
         4'd3:    code = 8'h79;
         4'd4:    code = 8'h33;
         4'd5:    code = 8'h5B;
         4'd6:    code = 8'h5F;
         4'd7:    code = 8'h70;
         4'd8:    code = 8'h7F;
         4'd9:    code = 8'h7B;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

### rtl/decimal_seven_segment_frame_sender.sv
`timescale 1ns / 1ps
// Path: 16 conversion cells, then the sender's segment registers, then its output register.
// The sender emits one beat per cycle while rsp_tready allows, and takes the next number as its last beat loads.
// Each number yields ten beats: two five-byte module frames.
// Reset: synchronous, active high; clears all valid flags, the busy flag and the beat counter.
module decimal_seven_segment_frame_sender (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic [0:0]  req_tuser,   // display_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // serial_byte[7:0]
   output logic [2:0]  rsp_tuser,   // module_select[1:0], frame_end
   output logic        rsp_tlast    // last
);
   import dssf_pkg::*;

   localparam int CELLS = VALUE_W;

   logic          vld  [CELLS+1];
   cell_data_type data [CELLS+1];
   logic          advance;
   logic          take;

   assign vld[0]        = req_tvalid;
   assign data[0].line  = req_tuser[0];
   assign data[0].bin   = req_tdata;
   assign data[0].bcd   = '0;
   assign data[0].big   = 1'b0;

   assign advance    = !vld[CELLS] || take;
   assign req_tready = advance;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      dssf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .prev_valid (vld[i]),
         .prev_data  (data[i]),
         .cur_valid  (vld[i+1]),
         .cur_data   (data[i+1])
      );
   end

   dssf_sender u_sender (
      .clock      (clock),
      .reset      (reset),
      .cell_valid (vld[CELLS]),
      .cell_data  (data[CELLS]),
      .cell_take  (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/dssf_cell.sv
`timescale 1ns / 1ps
module dssf_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   prev_valid,
   input  dssf_pkg::cell_data_type prev_data,
   output logic                   cur_valid,
   output dssf_pkg::cell_data_type cur_data
);
   import dssf_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff;
   cell_data_type data_in;
   logic [BCD_W-1:0] adj;

   // add-3 then shift one binary bit into the BCD word
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         adj[4*d +: 4] = (prev_data.bcd[4*d +: 4] >= 4'd5) ?
                         prev_data.bcd[4*d +: 4] + 4'd3 : prev_data.bcd[4*d +: 4];
      end
      data_in.line = prev_data.line;
      data_in.bin  = {prev_data.bin[VALUE_W-2:0], 1'b0};
      data_in.bcd  = {adj[BCD_W-2:0], prev_data.bin[VALUE_W-1]};
      data_in.big  = prev_data.big | adj[BCD_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign cur_valid = valid_ff;
   assign cur_data  = data_ff;

endmodule

### rtl/dssf_sender.sv
`timescale 1ns / 1ps
module dssf_sender (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cell_valid,
   input  dssf_pkg::cell_data_type cell_data,
   output logic                    cell_take,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic [2:0]              rsp_tuser,
   output logic                    rsp_tlast
);
   import dssf_pkg::*;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             line_ff;
   logic [7:0]       seg_ff [DIGITS];
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff;
   logic [1:0]       out_sel_ff;
   logic             out_fend_ff;
   logic             out_last_ff;
   logic             load_out;
   logic             frame;
   logic [2:0]       bidx;
   logic [7:0]       byte_now;
   logic [3:0]       d3, d2, d1, d0;
   logic             blank3, blank2, blank1;

   assign d3 = cell_data.bcd[15:12];
   assign d2 = cell_data.bcd[11:8];
   assign d1 = cell_data.bcd[7:4];
   assign d0 = cell_data.bcd[3:0];
   assign blank3 = !cell_data.big && (d3 == 4'd0);
   assign blank2 = blank3 && (d2 == 4'd0);
   assign blank1 = blank2 && (d1 == 4'd0);

   assign load_out  = busy_ff && (!out_valid_ff || rsp_tready);
   assign cell_take = cell_valid && (!busy_ff || (load_out && cnt_ff == LAST_BEAT));

   always_comb begin
      frame = (cnt_ff >= CNT_W'(FRAME_LEN));
      bidx  = frame ? 3'(cnt_ff - CNT_W'(FRAME_LEN)) : 3'(cnt_ff);
      case (bidx)
         3'd0:    byte_now = START_BIT | (frame ? seg_ff[1] : seg_ff[3]);
         3'd1:    byte_now = frame ? seg_ff[0] : seg_ff[2];
         default: byte_now = 8'h00;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (cell_take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (load_out) begin
         if (cnt_ff == LAST_BEAT) begin
            busy_in = 1'b0;
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_take) begin
         line_ff   <= cell_data.line;
         seg_ff[3] <= blank3 ? 8'h00 : seg_code(d3);
         seg_ff[2] <= blank2 ? 8'h00 : seg_code(d2);
         seg_ff[1] <= blank1 ? 8'h00 : seg_code(d1);
         seg_ff[0] <= seg_code(d0);
      end
      if (load_out) begin
         out_byte_ff <= byte_now;
         out_sel_ff  <= {line_ff, frame};
         out_fend_ff <= (bidx == 3'(FRAME_LEN - 1));
         out_last_ff <= (cnt_ff == LAST_BEAT);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_fend_ff, out_sel_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

### sim/decimal_seven_segment_frame_sender_test.sv
`timescale 1ns / 1ps
module decimal_seven_segment_frame_sender_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PER_PHASE = 52;
   localparam int DIR_ROWS = 24;
   localparam logic [7:0] FRAME_START = 8'h80;

   typedef struct packed {
      logic [1:0] module_sel;
      logic [7:0] seg_byte;
      logic       frame_end;
      logic       final_beat;
   } beat_type;

   // line, value, bytes typed in, bytes {lo byte0, lo byte1, hi byte0, hi byte1}
   typedef struct packed {
      logic        line;
      logic [15:0] value;
      logic        typed;
      logic [31:0] bytes;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;   // value[15:0]
   logic [0:0]  req_tuser = 1'b0;    // display_line
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // serial_byte[7:0]
   logic [2:0]  rsp_tuser;           // module_select[1:0], frame_end
   logic        rsp_tlast;           // last

   beat_type beats_due[$];
   int    mismatch_count = 0;
   int    cycle_count = 0;
   int    req_idle_pct = 0;
   int    rsp_idle_pct = 0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      {1'b0, 16'd0,     1'b1, 32'h8000_807E},
      {1'b1, 16'd0,     1'b1, 32'h8000_807E},
      {1'b1, 16'd65535, 1'b1, 32'hDB5B_F95B},
      {1'b0, 16'd9999,  1'b1, 32'hFB7B_FB7B},
      {1'b1, 16'd10000, 1'b1, 32'hFE7E_FE7E},
      {1'b0, 16'd1,     1'b1, 32'h8000_8030},
      {1'b1, 16'd9,     1'b0, 32'h0},
      {1'b0, 16'd10,    1'b0, 32'h0},
      {1'b1, 16'd99,    1'b0, 32'h0},
      {1'b0, 16'd100,   1'b0, 32'h0},
      {1'b1, 16'd999,   1'b0, 32'h0},
      {1'b0, 16'd1000,  1'b0, 32'h0},
      {1'b1, 16'd1001,  1'b0, 32'h0},
      {1'b0, 16'd32767, 1'b0, 32'h0},
      {1'b1, 16'd32768, 1'b0, 32'h0},
      {1'b0, 16'd12345, 1'b0, 32'h0},
      {1'b1, 16'd20000, 1'b0, 32'h0},
      {1'b0, 16'hAAAA,  1'b0, 32'h0},
      {1'b1, 16'h5555,  1'b0, 32'h0},
      {1'b0, 16'd60000, 1'b0, 32'h0},
      {1'b1, 16'd10009, 1'b0, 32'h0},
      {1'b0, 16'd4567,  1'b0, 32'h0},
      {1'b1, 16'd8080,  1'b0, 32'h0},
      {1'b0, 16'd65534, 1'b0, 32'h0}
   };

   decimal_seven_segment_frame_sender uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic logic [7:0] segments_of(input int digit);
      case (digit)
         0:       return 8'h7E;
         1:       return 8'h30;
         2:       return 8'h6D;
         3:       return 8'h79;
         4:       return 8'h33;
         5:       return 8'h5B;
         6:       return 8'h5F;
         7:       return 8'h70;
         8:       return 8'h7F;
         default: return 8'h7B;
      endcase
   endfunction

   // leading positions blank below their place value; ones always lit
   function automatic logic [7:0] place_segments(input logic [15:0] value, input int place);
      if (place > 1 && int'(value) < place) return 8'h00;
      return segments_of((int'(value) / place) % 10);
   endfunction

   function automatic logic [31:0] digit_bytes(input logic [15:0] value);
      return {FRAME_START | place_segments(value, 1000), place_segments(value, 100),
              FRAME_START | place_segments(value, 10), place_segments(value, 1)};
   endfunction

   task automatic queue_frames(input logic line, input logic [31:0] bytes);
      beat_type b;
      for (int f = 0; f < 2; f++) begin
         for (int k = 0; k < 5; k++) begin
            b.module_sel = {line, f[0]};
            b.seg_byte   = (k == 0) ? bytes[31 - 16 * f -: 8] :
                           (k == 1) ? bytes[23 - 16 * f -: 8] : 8'h00;
            b.frame_end  = (k == 4);
            b.final_beat = (k == 4 && f == 1);
            beats_due.push_back(b);
         end
      end
   endtask

   task automatic send_number(input logic line, input logic [15:0] value,
                              input logic typed, input logic [31:0] bytes);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= line;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      queue_frames(line, typed ? bytes : digit_bytes(value));
   endtask

   function automatic logic [15:0] random_value();
      case ($urandom_range(0, 4))
         0:       return 16'($urandom_range(0, 99));
         1:       return 16'($urandom_range(100, 9999));
         2:       return 16'($urandom_range(9990, 10010));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic wait_drained();
      while (beats_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("decimal_seven_segment_frame_sender_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_side
      beat_type got;
      beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser[1:0], rsp_tdata, rsp_tuser[2], rsp_tlast};
            if (beats_due.size() == 0) begin
               $display("%0t unexpected beat: got mod=%0d byte=%h fend=%b last=%b",
                        $time, got.module_sel, got.seg_byte, got.frame_end, got.final_beat);
               mismatch_count++;
            end else begin
               want = beats_due.pop_front();
               if (got !== want) begin
                  $display("%0t mismatch: expected mod=%0d byte=%h fend=%b last=%b, got mod=%0d byte=%h fend=%b last=%b",
                           $time, want.module_sel, want.seg_byte, want.frame_end,
                           want.final_beat, got.module_sel, got.seg_byte,
                           got.frame_end, got.final_beat);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 34;
      rsp_idle_pct = 72;
      for (int i = 0; i < DIR_ROWS; i++)
         send_number(dir_rows[i].line, dir_rows[i].value, dir_rows[i].typed,
                     dir_rows[i].bytes);
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
         send_number(1'($urandom_range(0, 1)), random_value(), 1'b0, 32'h0);
      req_tvalid <= 1'b0;
      wait_drained();

      req_idle_pct = 72;
      rsp_idle_pct = 34;
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
         send_number(1'($urandom_range(0, 1)), random_value(), 1'b0, 32'h0);
      req_tvalid <= 1'b0;
      wait_drained();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
         send_number(1'($urandom_range(0, 1)), random_value(), 1'b0, 32'h0);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && beats_due.size() == 0) begin
         $display("decimal_seven_segment_frame_sender_test OK");
      end else begin
         $display("decimal_seven_segment_frame_sender_test NOT OK");
      end
      $finish;
   end

endmodule

### decimal_seven_segment_frame_sender.f
rtl/dssf_pkg.sv
rtl/dssf_cell.sv
rtl/dssf_sender.sv
rtl/decimal_seven_segment_frame_sender.sv
sim/decimal_seven_segment_frame_sender_test.sv
